>>> sv/fde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter package
// Shared request and verdict types, byte codes and entry offsets.
// ----------------------------------------------------------------------------
package fde_pkg;

  // Entry layout
  localparam int unsigned PosWidth = 5;  // 32 bytes per entry

  localparam logic [PosWidth-1:0] NAME_LEN     = 5'd11;
  localparam logic [PosWidth-1:0] EXT_OFF      = 5'd8;
  localparam logic [PosWidth-1:0] ATTR_OFF     = 5'd11;
  localparam logic [PosWidth-1:0] CLU_HI_OFF   = 5'd20;
  localparam logic [PosWidth-1:0] CLU_HI_OFF_1 = 5'd21;
  localparam logic [PosWidth-1:0] CLU_LO_OFF   = 5'd26;
  localparam logic [PosWidth-1:0] CLU_LO_OFF_1 = 5'd27;
  localparam logic [PosWidth-1:0] SIZE_OFF     = 5'd28;
  localparam logic [PosWidth-1:0] LAST_OFF     = 5'd31;

  // Byte codes
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] DELETED_CODE = 8'hE5;
  localparam logic [7:0] DOT_CODE     = 8'h2E;

  // Attribute bits
  localparam int unsigned ATTR_VOLUME_BIT = 3;
  localparam int unsigned ATTR_DIR_BIT    = 4;

  // Extension register reset: "TAP"
  localparam logic [23:0] EXT_RESET = 24'h544150;

  typedef enum logic [1:0] {
    KIND_FILE   = 2'd0,
    KIND_SUBDIR = 2'd1,
    KIND_PARENT = 2'd2
  } entry_kind_e;

  typedef struct packed {
    logic [7:0] entry_byte;
    logic       entry_start;
  } entry_in_t;

  typedef struct packed {
    logic        accepted;
    entry_kind_e entry_kind;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
  } verdict_t;

endpackage
`default_nettype wire

>>> sv/fde_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter input register
// Holds one accepted byte request until the parser consumes it.
// ----------------------------------------------------------------------------
module fde_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fde_pkg::entry_in_t in_data_i,
  input  wire logic              advance_i,
  output logic                   item_valid_o,
  output fde_pkg::entry_in_t     item_o
);

  logic               valid_q, valid_d;
  fde_pkg::entry_in_t data_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = data_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/fde_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter parser
// Per-byte entry state and the verdict formed on the last byte.
// ----------------------------------------------------------------------------
module fde_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               item_valid_i,
  input  wire fde_pkg::entry_in_t item_i,
  input  wire logic               take_i,
  input  wire logic [23:0]        wanted_ext_i,
  output logic                    is_last_o,
  output fde_pkg::verdict_t       verdict_o
);

  logic [fde_pkg::PosWidth-1:0] pos_q, pos_d, pos;
  logic                         nv_q, nv_d;
  logic [7:0]                   first_q, first_d;
  logic [7:0]                   second_q, second_d;
  logic [23:0]                  ext_q, ext_d;
  logic [7:0]                   attr_q, attr_d;
  logic [15:0]                  clu_hi_q, clu_hi_d;
  logic [15:0]                  clu_lo_q, clu_lo_d;
  logic [31:0]                  size_q, size_d;
  logic                         clear;
  logic [7:0]                   b;
  logic                         ok;
  fde_pkg::entry_kind_e         kind;

  always_comb begin
    // start mark, or wrap to offset 0, opens a fresh entry
    clear    = item_i.entry_start || (pos_q == '0);
    pos      = clear ? '0 : pos_q;
    b        = item_i.entry_byte;
    nv_d     = clear ? 1'b1  : nv_q;
    first_d  = clear ? 8'h00 : first_q;
    second_d = clear ? 8'h00 : second_q;
    ext_d    = clear ? 24'h0 : ext_q;
    attr_d   = clear ? 8'h00 : attr_q;
    clu_hi_d = clear ? 16'h0 : clu_hi_q;
    clu_lo_d = clear ? 16'h0 : clu_lo_q;
    size_d   = clear ? 32'h0 : size_q;

    if (pos < fde_pkg::NAME_LEN) begin
      if (b < fde_pkg::SPACE_CODE) begin
        nv_d = 1'b0;
      end
      if (pos == '0) begin
        if (b == fde_pkg::SPACE_CODE || b == fde_pkg::DELETED_CODE) begin
          nv_d = 1'b0;
        end
        first_d = b;
      end else if (pos == 5'd1) begin
        second_d = b;
        // single-dot name
        if (first_d == fde_pkg::DOT_CODE && b != fde_pkg::DOT_CODE) begin
          nv_d = 1'b0;
        end
      end
      if (pos >= fde_pkg::EXT_OFF) begin
        ext_d = {ext_d[15:0], b};
      end
    end else if (pos == fde_pkg::ATTR_OFF) begin
      attr_d = b;
    end else if (pos == fde_pkg::CLU_HI_OFF) begin
      clu_hi_d[7:0] = b;
    end else if (pos == fde_pkg::CLU_HI_OFF_1) begin
      clu_hi_d[15:8] = b;
    end else if (pos == fde_pkg::CLU_LO_OFF) begin
      clu_lo_d[7:0] = b;
    end else if (pos == fde_pkg::CLU_LO_OFF_1) begin
      clu_lo_d[15:8] = b;
    end else if (pos >= fde_pkg::SIZE_OFF) begin
      size_d[{pos[1:0], 3'b000} +: 8] = b;
    end

    pos_d = pos + 5'd1;
  end

  // Verdict from the state as updated by the last byte
  always_comb begin
    ok   = nv_d && !attr_d[fde_pkg::ATTR_VOLUME_BIT];
    kind = fde_pkg::KIND_FILE;
    if (ok) begin
      if (!attr_d[fde_pkg::ATTR_DIR_BIT]) begin
        ok = (ext_d == wanted_ext_i);
      end else if (first_d == fde_pkg::DOT_CODE && second_d == fde_pkg::DOT_CODE) begin
        kind = fde_pkg::KIND_PARENT;
      end else begin
        kind = fde_pkg::KIND_SUBDIR;
      end
    end
    verdict_o.accepted      = ok;
    verdict_o.entry_kind    = ok ? kind : fde_pkg::KIND_FILE;
    verdict_o.first_cluster = ok ? {clu_hi_d, clu_lo_d} : 32'h0;
    verdict_o.file_size     = ok ? size_d : 32'h0;
  end

  assign is_last_o = item_valid_i && (pos == fde_pkg::LAST_OFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      nv_q  <= 1'b1;
    end else if (take_i) begin
      pos_q <= pos_d;
      nv_q  <= nv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      ext_q    <= ext_d;
      attr_q   <= attr_d;
      clu_hi_q <= clu_hi_d;
      clu_lo_q <= clu_lo_d;
      size_q   <= size_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/fde_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter output register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module fde_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire fde_pkg::verdict_t verdict_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fde_pkg::verdict_t      out_data_o
);

  logic              valid_q, valid_d;
  fde_pkg::verdict_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= verdict_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/fat_directory_entry_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter
// Screens 32-byte FAT short directory entries streamed one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one byte request per handshake; entry_start marks offset 0 and
//            realigns the byte count. Without it, counting wraps after 31.
//   out_*  : one verdict per entry, issued for the byte at offset 31 only:
//            accepted, kind (file/subdir/parent), first cluster, size.
//            Rejected entries report all-zero fields with accepted low.
//   cfg_*  : writes the 24-bit extension plain files must carry. Always
//            ready; write only while no entry is in flight.
// Path: the last byte of an entry sits in the input register, then the
//   per-byte logic loads its verdict into the output register, where the
//   receiver can take it.
// Throughput: one byte per cycle, from one per-byte pass, outside stalls.
// Stall: while the output register holds an untaken verdict, bytes that do
//   not end an entry keep flowing; an entry's last byte waits in the input
//   register until the verdict ahead of it leaves.
// Reset: byte count back to offset 0, extension register to "TAP", both
//   pipeline registers empty.
// ----------------------------------------------------------------------------
module fat_directory_entry_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fde_pkg::entry_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fde_pkg::verdict_t       out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [23:0]        cfg_data_i
);

  logic               item_valid;
  fde_pkg::entry_in_t item;
  logic               is_last;
  logic               out_free;
  logic               advance;
  fde_pkg::verdict_t  verdict;
  logic [23:0]        wanted_ext_q, wanted_ext_d;

  // Config register, written whenever requested
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wanted_ext_d = wanted_ext_q;
    if (cfg_valid_i && cfg_ready_o) begin
      wanted_ext_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_ext_q <= fde_pkg::EXT_RESET;
    end else begin
      wanted_ext_q <= wanted_ext_d;
    end
  end

  // Held byte moves on unless it ends an entry and the output is occupied
  assign advance = item_valid && (!is_last || out_free);

  fde_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fde_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_i       (advance),
    .wanted_ext_i (wanted_ext_q),
    .is_last_o    (is_last),
    .verdict_o    (verdict)
  );

  fde_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && is_last),
    .verdict_i   (verdict),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

>>> sv/fde_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FAT directory entry filter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module fde_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire fde_pkg::verdict_t  out_data_o
);

  // Pending verdict holds until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("verdict dropped or changed while stalled");

  // Rejected entries carry zero fields
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      out_data_o.entry_kind == fde_pkg::KIND_FILE &&
      out_data_o.first_cluster == 32'h0 && out_data_o.file_size == 32'h0)
    else $error("rejected verdict with nonzero fields");

  // A fresh verdict follows its accepted byte through both pipeline registers
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("verdict without a byte two cycles earlier");

  // Empty output means the input side is never blocked
  a_no_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind fat_directory_entry_filter fde_checker u_fde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

>>> bench/fat_directory_entry_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT directory entry filter testbench
// Streams 32-byte short directory entries, one byte request per handshake,
// through the filter. A directed table covers the corner entries, then random
// entries and noise run under several extension settings. Every verdict is
// checked field by field against its typed table verdict or a local model of
// the filter. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module fat_directory_entry_filter_tb;

  localparam int unsigned DRAIN_CYCLES = 4;        // two-stage pipe plus margin
  localparam int unsigned TIMEOUT_NS   = 8_000_000;
  localparam int unsigned PHASE_BYTES  = 120;
  localparam int unsigned NUM_ROWS     = 17;
  localparam fde_pkg::verdict_t REJECTED = '0;

  // One directory entry as the directed table and the random part see it.
  // Offset 0 of the name sits in bits 87:80, the extension in 23:0.
  typedef struct packed {
    logic [87:0] name;
    logic [7:0]  attr;
    logic [15:0] clu_hi;
    logic [15:0] clu_lo;
    logic [31:0] size;
    logic [4:0]  cut;      // bytes of an abandoned entry sent ahead, 0 for none
    logic        marked;   // start mark on offset 0
    logic        typed;    // verdict below is the expected one
    fde_pkg::verdict_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  fde_pkg::entry_in_t in_data;
  logic               out_valid;
  logic               out_ready;
  fde_pkg::verdict_t  out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [23:0]        cfg_data;

  // Model state: mirrors the filter's per-entry registers
  logic [4:0]  pos_q;
  logic        name_ok;
  logic [7:0]  name0;
  logic [7:0]  name1;
  logic [23:0] ext_acc;
  logic [7:0]  attr_q;
  logic [15:0] clu_hi_q;
  logic [15:0] clu_lo_q;
  logic [31:0] size_acc;
  logic [23:0] want_ext;

  fde_pkg::verdict_t verdict_q [$];     // verdicts still to come out, oldest first
  fde_pkg::verdict_t typed_verdict;
  bit          typed_pending;
  bit          steady_in;         // no input gaps for the current entry
  int unsigned verdicts_judged;
  int unsigned bytes_sent;
  int unsigned failures;
  int unsigned ready_left;
  dir_row_t    dir_rows [NUM_ROWS];

  fat_directory_entry_filter DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a verdict never shows up or a handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("fat_directory_entry_filter_tb failed");
    $finish;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long hole.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fde_pkg::verdict_t verdict(input logic acc,
                                                input fde_pkg::entry_kind_e kind,
                                                input logic [31:0] clu,
                                                input logic [31:0] size);
    fde_pkg::verdict_t v;
    v.accepted      = acc;
    v.entry_kind    = kind;
    v.first_cluster = clu;
    v.file_size     = size;
    return v;
  endfunction

  function automatic dir_row_t row(input logic [87:0] name, input logic [7:0] attr,
                                   input logic [15:0] hi, input logic [15:0] lo,
                                   input logic [31:0] size, input logic [4:0] cut,
                                   input logic marked, input logic typed,
                                   input fde_pkg::verdict_t want);
    dir_row_t r;
    r.name   = name;
    r.attr   = attr;
    r.clu_hi = hi;
    r.clu_lo = lo;
    r.size   = size;
    r.cut    = cut;
    r.marked = marked;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Filter model: takes one accepted byte request, may yield a verdict
  // --------------------------------------------------------------------------
  task automatic screen_byte(input fde_pkg::entry_in_t req, output bit got,
                             output fde_pkg::verdict_t v);
    logic [7:0]           b;
    logic                 keep;
    fde_pkg::entry_kind_e kind;
    int                   sh;
    b   = req.entry_byte;
    got = 1'b0;
    v   = REJECTED;
    // A start mark drops whatever was gathered; offset 0 starts fresh anyway
    if (req.entry_start || pos_q == '0) begin
      pos_q    = '0;
      name_ok  = 1'b1;
      name0    = '0;
      name1    = '0;
      ext_acc  = '0;
      attr_q   = '0;
      clu_hi_q = '0;
      clu_lo_q = '0;
      size_acc = '0;
    end
    if (pos_q < fde_pkg::NAME_LEN) begin
      if (b < fde_pkg::SPACE_CODE) name_ok = 1'b0;
      if (pos_q == '0) begin
        if (b == fde_pkg::SPACE_CODE || b == fde_pkg::DELETED_CODE) name_ok = 1'b0;
        name0 = b;
      end else if (pos_q == 5'd1) begin
        name1 = b;
        // lone dot is rejected, ".." is fine
        if (name0 == fde_pkg::DOT_CODE && b != fde_pkg::DOT_CODE) name_ok = 1'b0;
      end
      if (pos_q >= fde_pkg::EXT_OFF) ext_acc = {ext_acc[15:0], b};
    end else if (pos_q == fde_pkg::ATTR_OFF) begin
      attr_q = b;
    end else if (pos_q == fde_pkg::CLU_HI_OFF) begin
      clu_hi_q[7:0] = b;
    end else if (pos_q == fde_pkg::CLU_HI_OFF_1) begin
      clu_hi_q[15:8] = b;
    end else if (pos_q == fde_pkg::CLU_LO_OFF) begin
      clu_lo_q[7:0] = b;
    end else if (pos_q == fde_pkg::CLU_LO_OFF_1) begin
      clu_lo_q[15:8] = b;
    end else if (pos_q >= fde_pkg::SIZE_OFF) begin
      sh = 8 * (int'(pos_q) - int'(fde_pkg::SIZE_OFF));
      size_acc[sh +: 8] = b;
    end

    if (pos_q == fde_pkg::LAST_OFF) begin
      got  = 1'b1;
      keep = name_ok && !attr_q[fde_pkg::ATTR_VOLUME_BIT];
      kind = fde_pkg::KIND_FILE;
      if (keep) begin
        if (!attr_q[fde_pkg::ATTR_DIR_BIT]) begin
          if (ext_acc != want_ext) keep = 1'b0;
        end else if (name0 == fde_pkg::DOT_CODE && name1 == fde_pkg::DOT_CODE) begin
          kind = fde_pkg::KIND_PARENT;
        end else begin
          kind = fde_pkg::KIND_SUBDIR;
        end
      end
      if (keep) v = verdict(1'b1, kind, {clu_hi_q, clu_lo_q}, size_acc);
    end
    pos_q = pos_q + 5'd1;
  endtask

  // --------------------------------------------------------------------------
  // Request side. Valid is left high after a handshake and only changes at
  // the next falling edge, so each step sees one assignment at most.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic st);
    int unsigned       gap;
    bit                got;
    fde_pkg::verdict_t v;
    gap = steady_in ? 0 : draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.entry_byte  = b;
    in_data.entry_start = st;
    in_valid            = 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    screen_byte(in_data, got, v);
    if (got) begin
      verdicts_judged++;
      if (typed_pending) begin
        verdict_q.push_back(typed_verdict);
        typed_pending = 1'b0;
      end else begin
        verdict_q.push_back(v);
      end
    end
  endtask

  // Sends one entry; filler bytes between the fields are random.
  task automatic play_row(input dir_row_t r);
    logic [7:0] raw [32];
    for (int i = 0; i < 32; i++) raw[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 11; i++) raw[i] = r.name[87 - 8*i -: 8];
    raw[11] = r.attr;
    raw[20] = r.clu_hi[7:0];
    raw[21] = r.clu_hi[15:8];
    raw[26] = r.clu_lo[7:0];
    raw[27] = r.clu_lo[15:8];
    for (int i = 0; i < 4; i++) raw[28 + i] = r.size[8*i +: 8];
    // abandoned prefix, cut short by the start mark of the real entry
    for (int i = 0; i < int'(r.cut); i++) push_byte(raw[i], i == 0);
    typed_pending = r.typed;
    typed_verdict = r.want;
    for (int i = 0; i < 32; i++) push_byte(raw[i], (i == 0) && r.marked);
  endtask

  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return 8'($urandom_range(0, 31));
    if (r == 1) return 8'($urandom_range(128, 255));
    if (r == 2) return fde_pkg::SPACE_CODE;
    return 8'($urandom_range(33, 126));
  endfunction

  // Mostly sane entries with random content; bad names and odd attributes
  // show up often enough to hit every reject path.
  function automatic dir_row_t random_row();
    dir_row_t r;
    r = '0;
    for (int i = 0; i < 11; i++) r.name[87 - 8*i -: 8] = name_char();
    case ($urandom_range(0, 15))
      0:       r.name[87:80] = fde_pkg::DELETED_CODE;
      1:       r.name[87:80] = fde_pkg::SPACE_CODE;
      2:       r.name[87:80] = 8'($urandom_range(0, 31));
      3:       r.name[87:72] = {fde_pkg::DOT_CODE, fde_pkg::SPACE_CODE};
      4, 5:    r.name[87:72] = {fde_pkg::DOT_CODE, fde_pkg::DOT_CODE};
      6:       r.name[87:80] = 8'($urandom_range(0, 255));
      default: ;
    endcase
    if ($urandom_range(0, 9) < 6) r.name[23:0] = want_ext;
    case ($urandom_range(0, 11))
      0:       r.attr = 8'h00;
      1:       r.attr = 8'h01;
      2:       r.attr = 8'h02;
      3:       r.attr = 8'h04;
      4:       r.attr = 8'h10;
      5:       r.attr = 8'h12;
      6:       r.attr = 8'h20;
      7:       r.attr = 8'h30;
      8:       r.attr = 8'h08;
      9:       r.attr = 8'h0F;
      10:      r.attr = 8'h18;
      default: r.attr = 8'($urandom_range(0, 255));
    endcase
    r.clu_hi = 16'($urandom);
    r.clu_lo = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       r.size = '0;
      1:       r.size = $urandom_range(0, 65535);
      default: r.size = $urandom;
    endcase
    r.cut    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 30)) : 5'd0;
    r.marked = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  // Finish a partial entry so the filter sits at offset 0 again.
  task automatic close_entry();
    while (pos_q != '0) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Idle the request side and let every verdict drain. Bytes that end no
  // entry may still be in the pipe after the last verdict, hence the pause.
  task automatic await_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_extension(input logic [23:0] ext);
    close_entry();
    await_drain();
    cfg_data  = ext;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    want_ext = ext;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Verdict side: random back-pressure, runs of steady ready in between
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_left != 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready  = 1'b1;
      ready_left = $urandom_range(1, 40);
    end else begin
      out_ready  = 1'b0;
      ready_left = draw_gap();
    end
  end

  always @(posedge clk) begin : check_verdicts
    fde_pkg::verdict_t due;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict %h", $time, out_data);
        failures++;
      end else begin
        due = verdict_q.pop_front();
        if (out_data.accepted !== due.accepted) begin
          $display("%0t: accepted expected %b got %b", $time, due.accepted,
                   out_data.accepted);
          failures++;
        end
        if (out_data.entry_kind !== due.entry_kind) begin
          $display("%0t: entry_kind expected %0d got %0d", $time, due.entry_kind,
                   out_data.entry_kind);
          failures++;
        end
        if (out_data.first_cluster !== due.first_cluster) begin
          $display("%0t: first_cluster expected %h got %h", $time, due.first_cluster,
                   out_data.first_cluster);
          failures++;
        end
        if (out_data.file_size !== due.file_size) begin
          $display("%0t: file_size expected %h got %h", $time, due.file_size,
                   out_data.file_size);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [23:0]  ext_plan [4];
    int unsigned  phase_bytes;
    dir_row_t     r;

    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    ready_left = 0;
    failures   = 0;
    bytes_sent = 0;
    verdicts_judged = 0;
    typed_pending   = 1'b0;
    steady_in       = 1'b0;
    // model at reset
    pos_q    = '0;
    name_ok  = 1'b1;
    name0    = '0;
    name1    = '0;
    ext_acc  = '0;
    attr_q   = '0;
    clu_hi_q = '0;
    clu_lo_q = '0;
    size_acc = '0;
    want_ext = fde_pkg::EXT_RESET;

    // Directed entries, all under the reset extension "TAP". Typed verdicts
    // where obvious, the rest go through the model.
    dir_rows[0]  = row("GAME    TAP", 8'h20, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1, 1,
                       verdict(1'b1, fde_pkg::KIND_FILE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_rows[1]  = row("GAME    TAZ", 8'h20, 16'h0001, 16'h0002, 32'd100, 0, 1, 1,
                       REJECTED);  // wrong extension
    dir_rows[2]  = row("SUBDIR     ", 8'h10, 16'h0000, 16'h0000, 32'd0, 0, 1, 1,
                       verdict(1'b1, fde_pkg::KIND_SUBDIR, 32'd0, 32'd0));
    dir_rows[3]  = row("..         ", 8'h10, 16'h0000, 16'h1234, 32'd0, 0, 1, 1,
                       verdict(1'b1, fde_pkg::KIND_PARENT, 32'h0000_1234, 32'd0));
    dir_rows[4]  = row(".          ", 8'h10, 16'h0003, 16'h0004, 32'd0, 0, 1, 1,
                       REJECTED);  // single dot
    dir_rows[5]  = row({fde_pkg::DELETED_CODE, "ILE    TAP"}, 8'h20, 16'h1, 16'h2, 32'd7,
                       0, 1, 1, REJECTED);
    dir_rows[6]  = row(" ILE    TAP", 8'h20, 16'h1, 16'h2, 32'd7, 0, 1, 1, REJECTED);
    dir_rows[7]  = row({"GAME   ", 8'h1F, "TAP"}, 8'h20, 16'h1, 16'h2, 32'd7,
                       0, 1, 1, REJECTED);  // control char in name
    dir_rows[8]  = row({8'h00, "AME    TAP"}, 8'h20, 16'h1, 16'h2, 32'd7,
                       0, 1, 1, REJECTED);  // end-of-directory mark
    dir_rows[9]  = row("VOLUME  TAP", 8'h08, 16'h0, 16'h0, 32'd0, 0, 1, 1, REJECTED);
    // long-name slot: attribute 0x0F carries the volume bit
    dir_rows[10] = row({"AL", 8'h00, "O", 8'h00, "N", 8'h00, "G", 8'h00, "N", 8'h00},
                       8'h0F, 16'h0, 16'h0, 32'd0, 0, 1, 1, REJECTED);
    dir_rows[11] = row("GAMES      ", 8'h18, 16'h5, 16'h6, 32'd0, 0, 1, 1, REJECTED);
    // start mark in the middle of an entry
    dir_rows[12] = row("GAME    TAP", 8'h21, 16'hA5A5, 16'h5A5A, 32'h0102_0304,
                       13, 1, 0, REJECTED);
    // no start mark: relies on the count wrapping after offset 31
    dir_rows[13] = row("GAME    TAP", 8'h00, 16'h8000, 16'h0001, 32'h8000_0000,
                       0, 0, 0, REJECTED);
    dir_rows[14] = row("..      TAP", 8'h20, 16'h0, 16'h7, 32'd12, 0, 1, 0, REJECTED);
    dir_rows[15] = row("..         ", 8'h12, 16'h0, 16'h2, 32'd0, 0, 1, 0, REJECTED);
    dir_rows[16] = row({64'hFFFF_FFFF_FFFF_FFFF, "TAP"}, 8'hE7, 16'hFFFF, 16'h0,
                       32'h00FF_00FF, 0, 1, 0, REJECTED);

    ext_plan[0] = 24'h000000;
    ext_plan[1] = 24'hFFFFFF;
    ext_plan[2] = 24'($urandom);
    ext_plan[3] = fde_pkg::EXT_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) play_row(dir_rows[i]);

    // Random part, one phase per extension setting
    foreach (ext_plan[p]) begin
      set_extension(ext_plan[p]);
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < PHASE_BYTES) begin
        steady_in = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 11) == 0) begin
          // noise: loose bytes with the odd start mark
          repeat ($urandom_range(1, 40))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
          r = random_row();
          play_row(r);
        end
      end
      steady_in = 1'b0;
    end

    close_entry();
    await_drain();
    repeat (10) @(negedge clk);
    if (failures == 0 && verdict_q.size() == 0) begin
      $display("fat_directory_entry_filter_tb passed");
    end else begin
      $display("fat_directory_entry_filter_tb failed");
    end
    $finish;
  end

endmodule
